// ===== rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit free-list allocator.
// Used by ffa_cell, ffa_proc and the top level; depends on nothing.
package ffa_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] PAGE_ROUND_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_ROUND_MASK = 32'hffff_f000;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;

  localparam int OUT_BITS = 32 + 2 + 32 + CNT_W + CNT_W + 32 + 32;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_W     = 64;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [31:0]      lost_bytes;
    logic [31:0]      lost_count;
    logic [CNT_W-1:0] peak_entries;
    logic [CNT_W-1:0] entries_used;
    logic [31:0]      total_free;
    logic [1:0]       status;
    logic [31:0]      granted_addr;
  } result_t;

endpackage

// ===== rtl/first_fit_free_list_allocator.sv =====
// First-fit free-list allocator with coalescing: a ring of TABLE_ENTRIES cells
// rotates once per request past a head unit that edits the sorted entry stream.
// A request is taken only while idle; after a full ring rotation the result is
// loaded into the output register, and only then is the next request taken.
// A new request is taken while the previous result word still waits.
// Reset (rst_ni low, async) clears counters and handshakes; cell contents stay.
module first_fit_free_list_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ffa_pkg::IN_W-1:0]    s_axis_tdata,  // request_size, release_addr
  input  logic [1:0]                  s_axis_tuser,  // kind, round_to_page
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // granted_addr, status, total_free, entries_used, peak_entries, lost_count, lost_bytes
  output logic [ffa_pkg::OUT_W-1:0]   m_axis_tdata
);
  import ffa_pkg::*;

  entry_t  cell_q [TABLE_ENTRIES];
  entry_t  emit;
  logic    shift, ready, res_valid, res_ack, start;
  req_t    req;
  result_t res;
  logic [31:0] raw_size;
  logic        out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  assign raw_size = s_axis_tdata[31:0];
  assign req.kind = s_axis_tuser[0];
  assign req.size = s_axis_tuser[1] ? ((raw_size + PAGE_ROUND_ADD) & PAGE_ROUND_MASK)
                                    : raw_size;
  assign req.addr = s_axis_tdata[63:32];
  assign s_axis_tready = ready;
  assign start = s_axis_tvalid && ready;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ffa_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .d_i     ((i == 0) ? emit : cell_q[(i == 0) ? 0 : i - 1]),
      .q_o     (cell_q[i])
    );
  end

  ffa_proc u_proc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .ready_o     (ready),
    .shift_o     (shift),
    .cur_i       (cell_q[TABLE_ENTRIES-1]),
    .nxt_i       (cell_q[TABLE_ENTRIES-2]),
    .emit_o      (emit),
    .res_valid_o (res_valid),
    .res_ack_i   (res_ack),
    .res_o       (res)
  );

  // load the output word once the slot is free
  assign res_ack = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_data_q <= OUT_W'(res);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/ffa_cell.sv =====
// One table cell of the free-region ring: holds one (start, length) entry.
// Depends on ffa_pkg.
module ffa_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  ffa_pkg::entry_t d_i,
  output ffa_pkg::entry_t q_o
);
  import ffa_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== rtl/ffa_proc.sv =====
// Head of the cell ring: scans the table once per request, edits the
// stream of entries passing through, and keeps the running statistics.
// Depends on ffa_pkg.
module ffa_proc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ffa_pkg::req_t    req_i,
  output logic             ready_o,
  output logic             shift_o,
  input  ffa_pkg::entry_t  cur_i,
  input  ffa_pkg::entry_t  nxt_i,
  output ffa_pkg::entry_t  emit_o,
  output logic             res_valid_o,
  input  logic             res_ack_i,
  output ffa_pkg::result_t res_o
);
  import ffa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_DEL  = 2'd1;
  localparam logic [1:0] M_INS  = 2'd2;
  localparam logic [1:0] M_REP  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic             done_q, done_d;
  req_t             req_q;
  entry_t           held_q, held_d;
  logic [31:0]      gr_q, gr_d;
  logic [1:0]       st_q, st_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [31:0]      lostc_q, lostc_d;
  logic [31:0]      lostb_q, lostb_d;
  logic [31:0]      free_q, free_d;
  entry_t           emit;

  logic [CNT_W-1:0] kx;
  logic             cur_v, nxt_v, full, last;
  logic [31:0]      rel_end;

  assign kx      = CNT_W'(k_q);
  assign cur_v   = kx < count_q;
  assign nxt_v   = (kx + CNT_W'(1)) < count_q;
  assign full    = count_q == CNT_W'(TABLE_ENTRIES);
  assign last    = k_q == IDX_W'(TABLE_ENTRIES - 1);
  assign rel_end = req_q.addr + req_q.size;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    k_d     = k_q;
    done_d  = done_q;
    held_d  = held_q;
    gr_d    = gr_q;
    st_d    = st_q;
    count_d = count_q;
    peak_d  = peak_q;
    lostc_d = lostc_q;
    lostb_d = lostb_q;
    free_d  = free_q;
    emit    = cur_i;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_RUN;
          mode_d  = M_NONE;
          k_d     = '0;
          done_d  = 1'b0;
          gr_d    = '0;
          st_d    = (req_i.kind == KIND_ALLOC) ? ST_NOFIT : ST_OK;
        end
      end
      S_RUN: begin
        k_d = k_q + IDX_W'(1);
        if (last) begin
          state_d = S_FIN;
        end
        unique case (mode_q)
          M_DEL: emit = nxt_i;
          M_INS: begin
            emit   = held_q;
            held_d = cur_i;
          end
          M_REP: begin
            emit   = held_q;
            mode_d = M_NONE;
          end
          default: begin
            if (!done_q) begin
              if (req_q.kind == KIND_ALLOC) begin
                if (cur_v && cur_i.len >= req_q.size) begin
                  done_d = 1'b1;
                  gr_d   = cur_i.start;
                  st_d   = ST_OK;
                  free_d = free_q - req_q.size;
                  if (cur_i.len == req_q.size) begin
                    // region used up: close the gap
                    emit    = nxt_i;
                    mode_d  = M_DEL;
                    count_d = count_q - CNT_W'(1);
                  end else begin
                    emit = '{start: cur_i.start + req_q.size,
                             len:   cur_i.len - req_q.size};
                  end
                end
              end else if (k_q == '0 && (count_q == '0 || req_q.addr < cur_i.start)) begin
                // release goes in front of every entry
                done_d = 1'b1;
                if (cur_v && rel_end == cur_i.start) begin
                  emit   = '{start: req_q.addr, len: cur_i.len + req_q.size};
                  free_d = free_q + req_q.size;
                end else if (!full) begin
                  emit    = '{start: req_q.addr, len: req_q.size};
                  held_d  = cur_i;
                  mode_d  = M_INS;
                  count_d = count_q + CNT_W'(1);
                  free_d  = free_q + req_q.size;
                end else begin
                  st_d    = ST_LOST;
                  lostc_d = lostc_q + 32'd1;
                  lostb_d = lostb_q + req_q.size;
                end
              end else if (cur_v && req_q.addr >= cur_i.start &&
                           (!nxt_v || req_q.addr < nxt_i.start)) begin
                // release belongs right after this entry
                done_d = 1'b1;
                if (cur_i.start + cur_i.len == req_q.addr) begin
                  free_d = free_q + req_q.size;
                  if (nxt_v && rel_end == nxt_i.start) begin
                    emit    = '{start: cur_i.start,
                                len:   cur_i.len + req_q.size + nxt_i.len};
                    mode_d  = M_DEL;
                    count_d = count_q - CNT_W'(1);
                  end else begin
                    emit = '{start: cur_i.start, len: cur_i.len + req_q.size};
                  end
                end else if (nxt_v && rel_end == nxt_i.start) begin
                  held_d = '{start: req_q.addr, len: nxt_i.len + req_q.size};
                  mode_d = M_REP;
                  free_d = free_q + req_q.size;
                end else if (!full) begin
                  held_d  = '{start: req_q.addr, len: req_q.size};
                  mode_d  = M_INS;
                  count_d = count_q + CNT_W'(1);
                  free_d  = free_q + req_q.size;
                end else begin
                  st_d    = ST_LOST;
                  lostc_d = lostc_q + 32'd1;
                  lostb_d = lostb_q + req_q.size;
                end
              end
            end
          end
        endcase
        if (peak_q < count_d) begin
          peak_d = count_d;
        end
      end
      S_FIN: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_NONE;
      k_q     <= '0;
      done_q  <= 1'b0;
      count_q <= '0;
      peak_q  <= '0;
      lostc_q <= '0;
      lostb_q <= '0;
      free_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      k_q     <= k_d;
      done_q  <= done_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      lostc_q <= lostc_d;
      lostb_q <= lostb_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    gr_q   <= gr_d;
    st_q   <= st_d;
    if (start_i && state_q == S_IDLE) begin
      req_q <= req_i;
    end
  end

  assign ready_o     = state_q == S_IDLE;
  assign shift_o     = state_q == S_RUN;
  assign emit_o      = emit;
  assign res_valid_o = state_q == S_FIN;
  assign res_o = '{lost_bytes: lostb_q, lost_count: lostc_q, peak_entries: peak_q,
                   entries_used: count_q, total_free: free_q, status: st_q,
                   granted_addr: gr_q};

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES)) else $error("entry count beyond table");
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= count_q) else $error("peak below entry count");
  a_mode_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != M_NONE) |-> done_q) else $error("edit mode without decision");
  a_fin_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && req_q.kind == KIND_RELEASE) |-> done_q)
    else $error("release finished undecided");
`endif

endmodule
